FILE: hw/rtl/slr_pkg.sv
// package for the slr expression parser: codes, parse tables and stack constants
package slr_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int NUM_TOKENS      = 9;
    localparam int MAX_RESULTS     = 64;
    localparam int STATE_W         = 5;

    // token codes
    localparam logic [3:0] T_END   = 4'd0;
    localparam logic [3:0] T_LPAR  = 4'd1;
    localparam logic [3:0] T_RPAR  = 4'd2;
    localparam logic [3:0] T_PLUS  = 4'd3;
    localparam logic [3:0] T_MINUS = 4'd4;
    localparam logic [3:0] T_MUL   = 4'd5;
    localparam logic [3:0] T_DIV   = 4'd6;
    localparam logic [3:0] T_ID    = 4'd7;
    localparam logic [3:0] T_NUM   = 4'd8;

    // result kinds
    localparam logic [3:0] K_SHIFT    = 4'd0;
    localparam logic [3:0] K_REDUCE   = 4'd1;
    localparam logic [3:0] K_ACCEPT   = 4'd2;
    localparam logic [3:0] K_E1       = 4'd3;
    localparam logic [3:0] K_E2       = 4'd4;
    localparam logic [3:0] K_E3       = 4'd5;
    localparam logic [3:0] K_STUCK    = 4'd6;
    localparam logic [3:0] K_IGNORED  = 4'd7;
    localparam logic [3:0] K_OVERFLOW = 4'd8;

    // nonterminal goto columns
    localparam logic [1:0] NT_E = 2'd0;
    localparam logic [1:0] NT_T = 2'd1;
    localparam logic [1:0] NT_F = 2'd2;

    typedef enum logic [2:0] {
        A_SHIFT,
        A_REDUCE,
        A_ACCEPT,
        A_E1,
        A_E2,
        A_E3,
        A_EMPTY
    } act_t;

    typedef struct packed {
        act_t                 kind;
        logic [STATE_W-1:0]   value;
    } act_entry_t;

    typedef struct packed {
        logic       last;
        logic [4:0] value;
        logic [3:0] kind;
    } out_beat_t;

    // production reduced in a state whose row holds reductions
    function automatic logic [4:0] red_prod(input logic [STATE_W-1:0] st);
        logic [4:0] p;
        case (st)
            5'd2:    p = 5'd4;
            5'd12:   p = 5'd2;
            5'd13:   p = 5'd3;
            5'd3:    p = 5'd7;
            5'd4:    p = 5'd8;
            5'd6:    p = 5'd10;
            5'd14:   p = 5'd5;
            5'd15:   p = 5'd6;
            5'd16:   p = 5'd9;
            default: p = 5'd0;
        endcase
        return p;
    endfunction

    function automatic act_entry_t act_lookup(input logic [STATE_W-1:0] st,
                                              input logic [3:0] tok);
        act_entry_t e;
        e = '{A_EMPTY, 5'd0};
        case (st)
            5'd0, 5'd5, 5'd7, 5'd8, 5'd9, 5'd10: begin
                case (tok)
                    T_END:   e.kind = (st == 5'd5) ? A_EMPTY : A_E1;
                    T_LPAR:  e = '{A_SHIFT, 5'd5};
                    T_RPAR:  e.kind = A_E2;
                    T_PLUS, T_MINUS, T_MUL, T_DIV: e.kind = A_E1;
                    T_ID:    e = '{A_SHIFT, 5'd4};
                    T_NUM:   e = '{A_SHIFT, 5'd6};
                    default: e.kind = A_EMPTY;
                endcase
            end
            5'd1, 5'd11: begin
                case (tok)
                    T_END:   e.kind = (st == 5'd1) ? A_ACCEPT : A_EMPTY;
                    T_LPAR, T_ID, T_NUM: e.kind = A_E3;
                    T_RPAR: begin
                        if (st == 5'd1) e = '{A_E2, 5'd0};
                        else            e = '{A_SHIFT, 5'd16};
                    end
                    T_PLUS:  e = '{A_SHIFT, 5'd7};
                    T_MINUS: e = '{A_SHIFT, 5'd8};
                    default: e.kind = A_EMPTY;
                endcase
            end
            5'd2, 5'd12, 5'd13: begin
                case (tok)
                    T_END, T_RPAR, T_PLUS, T_MINUS: e = '{A_REDUCE, red_prod(st)};
                    T_LPAR, T_ID, T_NUM: e.kind = A_E3;
                    T_MUL:   e = '{A_SHIFT, 5'd9};
                    T_DIV:   e = '{A_SHIFT, 5'd10};
                    default: e.kind = A_EMPTY;
                endcase
            end
            5'd3, 5'd4, 5'd6, 5'd14, 5'd15, 5'd16: begin
                case (tok)
                    T_END, T_RPAR, T_PLUS, T_MINUS, T_MUL, T_DIV:
                        e = '{A_REDUCE, red_prod(st)};
                    default: e.kind = A_EMPTY;
                endcase
            end
            default: e.kind = A_EMPTY;
        endcase
        return e;
    endfunction

    function automatic logic [1:0] prod_len(input logic [4:0] p);
        logic [1:0] len;
        case (p)
            5'd4, 5'd7, 5'd8, 5'd10: len = 2'd1;
            default:                 len = 2'd3;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] prod_lhs(input logic [4:0] p);
        logic [1:0] nt;
        case (p)
            5'd2, 5'd3, 5'd4: nt = NT_E;
            5'd5, 5'd6, 5'd7: nt = NT_T;
            default:          nt = NT_F;
        endcase
        return nt;
    endfunction

    function automatic logic [STATE_W-1:0] goto_lookup(input logic [STATE_W-1:0] g,
                                                       input logic [1:0] nt);
        logic [STATE_W-1:0] t;
        t = '0;
        case (nt)
            NT_E: begin
                if (g == 5'd0)      t = 5'd1;
                else if (g == 5'd5) t = 5'd11;
            end
            NT_T: begin
                if (g == 5'd0 || g == 5'd5) t = 5'd2;
                else if (g == 5'd7)         t = 5'd12;
                else if (g == 5'd8)         t = 5'd13;
            end
            NT_F: begin
                if (g == 5'd0 || g == 5'd5 || g == 5'd7 || g == 5'd8) t = 5'd3;
                else if (g == 5'd9)  t = 5'd14;
                else if (g == 5'd10) t = 5'd15;
            end
            default: t = '0;
        endcase
        return t;
    endfunction

    // state pushed by missing-operator recovery, zero for none
    function automatic logic [STATE_W-1:0] e3_target(input logic [STATE_W-1:0] st,
                                                     input logic [3:0] nxt);
        logic [STATE_W-1:0] t;
        t = '0;
        case (st)
            5'd1:                t = 5'd7;
            5'd2, 5'd12, 5'd13:  t = 5'd9;
            5'd11: begin
                if (nxt == T_PLUS || nxt == T_MINUS || nxt == T_MUL || nxt == T_DIV)
                    t = 5'd16;
                else if (nxt == T_ID || nxt == T_NUM)
                    t = 5'd7;
            end
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

FILE: hw/rtl/slr_expression_parser.sv
// slr(1) arithmetic expression parser with a state stack in ram
//
//  channel | dir | tdata (low bit up)                | tuser            | tlast
//  s_      | in  | token[3:0], following_token[7:4] | -                | -
//  m_      | out | action_value[4:0], pad           | action_kind[3:0] | last_of_run
//
// a token is taken in the idle state; the decide state then gives each shift,
// accept or recovery result, and a reduction runs decide (pop address), then
// reduce (the stack ram's registered read feeds the goto lookup).
// synchronous active-low reset; the stack needs no clearing pass, entry 0 is
// supplied as state 0 on read. the decide and reduce states hold while the result
// register is full and m_tready is low.
module slr_expression_parser
    import slr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // token[3:0], following_token[7:4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // action_value[4:0], zero pad
    output logic [3:0]  m_tuser,   // action_kind[3:0]
    output logic        m_tlast
);

    localparam int TOP_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REDUCE
    } seq_t;

    seq_t               state_reg, state_next;
    logic [3:0]         tok_reg, tok_next;
    logic [3:0]         nxt_reg, nxt_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic [STATE_W-1:0] top_state_reg, top_state_next;
    logic               halted_reg, halted_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [4:0]         prod_reg, prod_next;
    logic               rd_zero_reg, rd_zero_next;
    logic               m_tvalid_reg, m_tvalid_next;
    out_beat_t          beat_reg, beat_next;

    logic               ram_we, ram_re;
    logic [TOP_W-1:0]   ram_waddr, ram_raddr;
    logic [STATE_W-1:0] ram_wdata, ram_rdata;

    act_entry_t         act;
    logic               slot_free, stack_full;
    logic [TOP_W-1:0]   top_plus;
    logic [1:0]         len;
    logic [STATE_W-1:0] e3_tgt, goto_state, base_state;

    slr_ram #(
        .WIDTH(STATE_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign act        = act_lookup(top_state_reg, tok_reg);
    assign slot_free  = !m_tvalid_reg || m_tready;
    assign stack_full = (top_reg == TOP_W'(STACK_DEPTH - 1));
    assign top_plus   = top_reg + TOP_W'(1);
    assign len        = prod_len(act.value);
    assign e3_tgt     = e3_target(top_state_reg, nxt_reg);
    assign base_state = rd_zero_reg ? '0 : ram_rdata;
    assign goto_state = goto_lookup(base_state, prod_lhs(prod_reg));

    always_comb begin
        state_next     = state_reg;
        tok_next       = tok_reg;
        nxt_next       = nxt_reg;
        top_next       = top_reg;
        top_state_next = top_state_reg;
        halted_next    = halted_reg;
        n_next         = n_reg;
        prod_next      = prod_reg;
        rd_zero_next   = rd_zero_reg;
        beat_next      = beat_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = top_plus;
        ram_wdata      = act.value;
        ram_raddr      = top_reg - TOP_W'(len);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tok_next   = s_tdata[3:0];
                    nxt_next   = s_tdata[7:4];
                    n_next     = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (halted_reg || tok_reg >= 4'(NUM_TOKENS)) begin
                        beat_next = '{1'b1, 5'd0, K_IGNORED};
                    end else if (n_reg == CNT_W'(MAX_RESULTS - 1)) begin
                        // runaway run
                        beat_next   = '{1'b1, 5'd0, K_STUCK};
                        halted_next = 1'b1;
                    end else begin
                        case (act.kind)
                            A_SHIFT: begin
                                if (stack_full) begin
                                    beat_next   = '{1'b1, 5'd0, K_OVERFLOW};
                                    halted_next = 1'b1;
                                end else begin
                                    ram_we         = 1'b1;
                                    top_next       = top_plus;
                                    top_state_next = act.value;
                                    beat_next      = '{1'b1, act.value, K_SHIFT};
                                end
                            end
                            A_REDUCE: begin
                                if (top_reg < TOP_W'(len)) begin
                                    beat_next   = '{1'b1, 5'd0, K_STUCK};
                                    halted_next = 1'b1;
                                end else begin
                                    // pop now, goto push once the read returns
                                    m_tvalid_next = m_tvalid_reg && !m_tready;
                                    ram_re        = 1'b1;
                                    rd_zero_next  = (ram_raddr == '0);
                                    top_next      = ram_raddr;
                                    prod_next     = act.value;
                                    state_next    = ST_REDUCE;
                                end
                            end
                            A_ACCEPT: begin
                                beat_next   = '{1'b1, 5'd0, K_ACCEPT};
                                halted_next = 1'b1;
                            end
                            A_E1: begin
                                if (stack_full) begin
                                    beat_next   = '{1'b1, 5'd0, K_OVERFLOW};
                                    halted_next = 1'b1;
                                end else begin
                                    // acts as if an id was read, token kept
                                    ram_we         = 1'b1;
                                    ram_wdata      = 5'd4;
                                    top_next       = top_plus;
                                    top_state_next = 5'd4;
                                    beat_next      = '{1'b0, 5'd0, K_E1};
                                    n_next         = n_reg + CNT_W'(1);
                                    state_next     = ST_DECIDE;
                                end
                            end
                            A_E2: begin
                                beat_next = '{1'b1, 5'd0, K_E2};
                            end
                            A_E3: begin
                                if (e3_tgt != '0 && stack_full) begin
                                    beat_next   = '{1'b1, 5'd0, K_OVERFLOW};
                                    halted_next = 1'b1;
                                end else begin
                                    if (e3_tgt != '0) begin
                                        ram_we         = 1'b1;
                                        ram_wdata      = e3_tgt;
                                        top_next       = top_plus;
                                        top_state_next = e3_tgt;
                                    end
                                    beat_next = '{1'b1, 5'd0, K_E3};
                                end
                            end
                            default: begin
                                beat_next   = '{1'b1, 5'd0, K_STUCK};
                                halted_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_REDUCE: begin
                if (slot_free) begin
                    // push after pop never passes the old top
                    ram_we         = 1'b1;
                    ram_wdata      = goto_state;
                    top_next       = top_plus;
                    top_state_next = goto_state;
                    beat_next      = '{1'b0, prod_reg, K_REDUCE};
                    m_tvalid_next  = 1'b1;
                    n_next         = n_reg + CNT_W'(1);
                    state_next     = ST_DECIDE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            top_state_reg <= '0;
            halted_reg    <= 1'b0;
            n_reg         <= '0;
            rd_zero_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            top_state_reg <= top_state_next;
            halted_reg    <= halted_next;
            n_reg         <= n_next;
            rd_zero_reg   <= rd_zero_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        tok_reg  <= tok_next;
        nxt_reg  <= nxt_next;
        prod_reg <= prod_next;
        beat_reg <= beat_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, beat_reg.value};
    assign m_tuser  = beat_reg.kind;
    assign m_tlast  = beat_reg.last;

    // once halted, only reset clears it
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted flag dropped");

    // the bottom entry is always the start state, outside the goto step
    a_bottom_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (top_reg == '0 && state_reg != ST_REDUCE) |-> (top_state_reg == '0))
        else $error("empty stack with nonzero top state");

    // a reduction never ends a run
    a_reduce_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == K_REDUCE) |-> !m_tlast)
        else $error("reduce beat marked last");

    // a pop only happens from the decide step
    a_reduce_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REDUCE) |-> ($past(state_reg) == ST_DECIDE ||
                                      $past(state_reg) == ST_REDUCE))
        else $error("reduce step entered out of sequence");

endmodule

FILE: hw/rtl/slr_ram.sv
// generic single write port ram with registered read
module slr_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: bench/tb_slr_expression_parser.sv
// self-checking testbench for the slr expression parser: token stream in, parse actions out
import slr_pkg::*;

class parse_tracker;
    localparam int DEPTH    = STACK_DEPTH_DEF;
    localparam int N_STATES = 17;
    // non-shift table entries
    localparam int NO_ENTRY = 0;
    localparam int OP_MISS  = 51;
    localparam int RP_DROP  = 52;
    localparam int OPR_MISS = 53;
    localparam int ACC      = 999;

    // columns: end ( ) + - * / id num; negative entries reduce by that production
    localparam int ACTION_TBL [N_STATES][NUM_TOKENS] = '{
        '{OP_MISS, 5, RP_DROP, OP_MISS, OP_MISS, OP_MISS, OP_MISS, 4, 6},
        '{ACC, OPR_MISS, RP_DROP, 7, 8, NO_ENTRY, NO_ENTRY, OPR_MISS, OPR_MISS},
        '{-4, OPR_MISS, -4, -4, -4, 9, 10, OPR_MISS, OPR_MISS},
        '{-7, NO_ENTRY, -7, -7, -7, -7, -7, NO_ENTRY, NO_ENTRY},
        '{-8, NO_ENTRY, -8, -8, -8, -8, -8, NO_ENTRY, NO_ENTRY},
        '{NO_ENTRY, 5, RP_DROP, OP_MISS, OP_MISS, OP_MISS, OP_MISS, 4, 6},
        '{-10, NO_ENTRY, -10, -10, -10, -10, -10, NO_ENTRY, NO_ENTRY},
        '{OP_MISS, 5, RP_DROP, OP_MISS, OP_MISS, OP_MISS, OP_MISS, 4, 6},
        '{OP_MISS, 5, RP_DROP, OP_MISS, OP_MISS, OP_MISS, OP_MISS, 4, 6},
        '{OP_MISS, 5, RP_DROP, OP_MISS, OP_MISS, OP_MISS, OP_MISS, 4, 6},
        '{OP_MISS, 5, RP_DROP, OP_MISS, OP_MISS, OP_MISS, OP_MISS, 4, 6},
        '{NO_ENTRY, OPR_MISS, 16, 7, 8, NO_ENTRY, NO_ENTRY, OPR_MISS, OPR_MISS},
        '{-2, OPR_MISS, -2, -2, -2, 9, 10, OPR_MISS, OPR_MISS},
        '{-3, OPR_MISS, -3, -3, -3, 9, 10, OPR_MISS, OPR_MISS},
        '{-5, NO_ENTRY, -5, -5, -5, -5, -5, NO_ENTRY, NO_ENTRY},
        '{-6, NO_ENTRY, -6, -6, -6, -6, -6, NO_ENTRY, NO_ENTRY},
        '{-9, NO_ENTRY, -9, -9, -9, -9, -9, NO_ENTRY, NO_ENTRY}
    };
    // goto columns E, T, F
    localparam int GOTO_TBL [N_STATES][3] = '{
        '{1, 2, 3}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0},
        '{11, 2, 3}, '{0, 0, 0}, '{0, 12, 3}, '{0, 13, 3}, '{0, 0, 14},
        '{0, 0, 15}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0},
        '{0, 0, 0}, '{0, 0, 0}
    };
    localparam int RHS_LEN [11] = '{0, 1, 3, 3, 1, 3, 3, 1, 1, 3, 1};
    localparam int LHS_COL [11] = '{NT_E, NT_E, NT_E, NT_E, NT_E, NT_T, NT_T, NT_T,
                                    NT_F, NT_F, NT_F};

    logic [4:0]  stk [DEPTH];
    int unsigned top;
    bit          halted;
    out_beat_t   pending_actions[$];
    int unsigned mismatches;

    function new();
        foreach (stk[i]) stk[i] = '0;
        top        = 0;
        halted     = 1'b0;
        mismatches = 0;
    endfunction

    function out_beat_t make_beat(logic [3:0] kind, int value, bit last);
        out_beat_t b;
        b.kind  = kind;
        b.value = 5'(value);
        b.last  = last;
        return b;
    endfunction

    // runs one token over a copy of the stack; returns the halted flag afterwards
    function bit parse_token(input logic [3:0] tok, input logic [3:0] nxt, input bit commit,
                             output out_beat_t run[$]);
        logic [4:0]  st [DEPTH];
        int unsigned sp;
        bit          stop, done, halting;
        logic [3:0]  halt_kind;
        int          act, len, g, tgt;
        st   = stk;
        sp   = top;
        stop = halted;
        done = 1'b0;
        run  = {};
        if (stop || tok >= NUM_TOKENS) begin
            run.push_back(make_beat(K_IGNORED, 0, 1'b1));
            done = 1'b1;
        end
        while (!done) begin
            halting   = 1'b0;
            halt_kind = K_STUCK;
            if (run.size() >= MAX_RESULTS - 1 || sp >= DEPTH || st[sp] >= N_STATES) begin
                halting = 1'b1;
            end else begin
                act = ACTION_TBL[st[sp]][tok];
                if (act > 0 && act < OP_MISS) begin
                    if (sp + 1 >= DEPTH) begin
                        halting   = 1'b1;
                        halt_kind = K_OVERFLOW;
                    end else begin
                        sp++;
                        st[sp] = 5'(act);
                        run.push_back(make_beat(K_SHIFT, act, 1'b1));
                        done = 1'b1;
                    end
                end else if (act < 0) begin
                    len = RHS_LEN[-act];
                    if (sp < len) begin
                        halting = 1'b1;
                    end else begin
                        sp -= len;
                        g = st[sp];
                        if (g >= N_STATES) begin
                            halting = 1'b1;
                        end else if (sp + 1 >= DEPTH) begin
                            halting   = 1'b1;
                            halt_kind = K_OVERFLOW;
                        end else begin
                            sp++;
                            st[sp] = 5'(GOTO_TBL[g][LHS_COL[-act]]);
                            run.push_back(make_beat(K_REDUCE, -act, 1'b0));
                        end
                    end
                end else if (act == ACC) begin
                    halting   = 1'b1;
                    halt_kind = K_ACCEPT;
                end else if (act == OP_MISS) begin
                    // missing operand: act as if an id was read, keep the token
                    if (sp + 1 >= DEPTH) begin
                        halting   = 1'b1;
                        halt_kind = K_OVERFLOW;
                    end else begin
                        sp++;
                        st[sp] = 5'd4;
                        run.push_back(make_beat(K_E1, 0, 1'b0));
                    end
                end else if (act == RP_DROP) begin
                    run.push_back(make_beat(K_E2, 0, 1'b1));
                    done = 1'b1;
                end else if (act == OPR_MISS) begin
                    tgt = 0;
                    case (st[sp])
                        5'd1:               tgt = 7;
                        5'd2, 5'd12, 5'd13: tgt = 9;
                        5'd11: begin
                            if (nxt >= T_PLUS && nxt <= T_DIV)
                                tgt = 16;
                            else if (nxt == T_ID || nxt == T_NUM)
                                tgt = 7;
                        end
                        default:            tgt = 0;
                    endcase
                    if (tgt != 0 && sp + 1 >= DEPTH) begin
                        halting   = 1'b1;
                        halt_kind = K_OVERFLOW;
                    end else begin
                        if (tgt != 0) begin
                            sp++;
                            st[sp] = 5'(tgt);
                        end
                        run.push_back(make_beat(K_E3, 0, 1'b1));
                        done = 1'b1;
                    end
                end else begin
                    halting = 1'b1;
                end
            end
            if (halting) begin
                run.push_back(make_beat(halt_kind, 0, 1'b1));
                stop = 1'b1;
                done = 1'b1;
            end
        end
        if (commit) begin
            stk    = st;
            top    = sp;
            halted = stop;
        end
        return stop;
    endfunction

    function void note_token(logic [3:0] tok, logic [3:0] nxt);
        out_beat_t run[$];
        void'(parse_token(tok, nxt, 1'b1, run));
        foreach (run[i]) pending_actions.push_back(run[i]);
    endfunction

    function bit would_halt(logic [3:0] tok, logic [3:0] nxt);
        out_beat_t scratch[$];
        return parse_token(tok, nxt, 1'b0, scratch) && !halted;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_beat(logic [7:0] data, logic [3:0] user, logic last);
        out_beat_t want;
        if (pending_actions.size() == 0) begin
            flag($sformatf("unexpected beat: kind %0d value %0d last %0d",
                           user, data[4:0], last));
        end else begin
            want = pending_actions.pop_front();
            if (user !== want.kind || data[4:0] !== want.value ||
                data[7:5] !== '0 || last !== want.last)
                flag($sformatf({"action mismatch: expected kind %0d value %0d last %0d,",
                                " got kind %0d value %0d last %0d pad %h"},
                               want.kind, want.value, want.last,
                               user, data[4:0], last, data[7:5]));
        end
    endfunction

    function bit wants_operand();
        case (stk[top])
            5'd0, 5'd5, 5'd7, 5'd8, 5'd9, 5'd10: return 1'b1;
            default:                             return 1'b0;
        endcase
    endfunction

    function int unsigned open_parens();
        int unsigned n;
        n = 0;
        for (int unsigned i = 1; i <= top; i++)
            if (stk[i] == 5'd5) n++;
        return n;
    endfunction
endclass

module tb_slr_expression_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 210;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam logic [3:0]  T_UNUSED_LO  = 4'd9;
    localparam logic [3:0]  T_UNUSED_HI  = 4'd15;

    // {following_token, token}
    localparam logic [7:0] DIRECTED [24] = '{
        {T_UNUSED_HI, T_UNUSED_HI}, {T_END, T_RPAR}, {T_MUL, T_PLUS}, {T_NUM, T_MUL},
        {T_DIV, T_NUM}, {T_LPAR, T_DIV}, {T_ID, T_LPAR}, {T_MINUS, T_ID},
        {T_NUM, T_MINUS}, {T_RPAR, T_NUM}, {T_PLUS, T_RPAR}, {T_NUM, T_PLUS},
        {T_RPAR, T_NUM}, {T_ID, T_RPAR}, {T_ID, T_ID}, {T_MUL, T_ID},
        {T_LPAR, T_MUL}, {T_NUM, T_LPAR}, {T_RPAR, T_NUM}, {T_MINUS, T_RPAR},
        {T_RPAR, T_MINUS}, {T_UNUSED_HI, T_RPAR}, {T_END, T_DIV}, {T_END, T_UNUSED_LO}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    parse_tracker sb;
    int unsigned  gap_pct     = 0;
    int unsigned  stall_pct   = 0;
    int unsigned  cycle_count = 0;

    slr_expression_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void set_mode(int unsigned mode);
        gap_pct   = (mode == 1) ? 78 : (mode == 3) ? 14 : 0;
        stall_pct = (mode == 2) ? 78 : (mode == 3) ? 14 : 0;
    endfunction

    task automatic send_token(input logic [3:0] tok, input logic [3:0] nxt);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt, tok};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        sb.note_token(tok, nxt);
    endtask

    // mostly grammatical, some noise; a token that would halt is redrawn, else made unused
    function automatic void pick_token(output logic [3:0] tok, output logic [3:0] nxt);
        int unsigned r, r2, tries;
        bit          deep;
        tries = 0;
        do begin
            deep = sb.top > 16;
            r    = $urandom_range(99);
            r2   = $urandom_range(99);
            nxt  = 4'($urandom_range(15));
            if (r < 8) begin
                tok = 4'($urandom_range(15));
            end else if (r < 12) begin
                tok = (r2 < 33) ? T_LPAR : (r2 < 66) ? T_ID : T_NUM;
            end else if (sb.wants_operand()) begin
                tok = (r2 < (deep ? 10 : 30)) ? T_LPAR : (r2 < 65) ? T_ID : T_NUM;
            end else begin
                tok = (r2 < (deep ? 60 : 20)) ? T_RPAR : 4'(T_PLUS + $urandom_range(3));
            end
            tries++;
        end while (sb.would_halt(tok, nxt) && tries < 30);
        if (sb.would_halt(tok, nxt)) tok = T_UNUSED_HI;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_beat(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout with %0d results outstanding", sb.pending_actions.size());
        $display("tb_slr_expression_parser: FAIL");
        $finish;
    end

    initial begin
        logic [3:0]  tok, nxt;
        int unsigned sent, n_open;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        set_mode(0);
        foreach (DIRECTED[i])
            if (!sb.would_halt(DIRECTED[i][3:0], DIRECTED[i][7:4]))
                send_token(DIRECTED[i][3:0], DIRECTED[i][7:4]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_mode((sent / 27) % 4);
            pick_token(tok, nxt);
            send_token(tok, nxt);
            if (tok < NUM_TOKENS) sent++;
        end

        // one terminating event per run, then a few tokens into the halted parser
        set_mode(3);
        case ($urandom_range(2))
            0: begin
                if (sb.wants_operand()) send_token(T_ID, T_END);
                n_open = sb.open_parens();
                repeat (n_open) send_token(T_RPAR, T_END);
                send_token(T_END, T_END);
            end
            1: begin
                send_token(T_LPAR, T_END);
                send_token(T_END, T_END);
            end
            default: begin
                while (!sb.halted) send_token(T_LPAR, T_LPAR);
            end
        endcase
        repeat (4) send_token(4'($urandom_range(15)), 4'($urandom_range(15)));
        s_tvalid <= 1'b0;

        while (sb.pending_actions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_actions.size() == 0)
            $display("tb_slr_expression_parser: PASS");
        else
            $display("tb_slr_expression_parser: FAIL");
        $finish;
    end
endmodule

FILE: slr_expression_parser.f
hw/rtl/slr_pkg.sv
hw/rtl/slr_ram.sv
hw/rtl/slr_expression_parser.sv
bench/tb_slr_expression_parser.sv
